// ===== rtl/assert_macros.svh =====
// assertion macros shared by the yenc decoder rtl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/yenc_pkg.sv =====
// types, codes and the crc byte update for the yenc body decoder
// no dependencies
package yenc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_CRC_CHECK_ENABLE = 1'd0;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic RESULT_BYTE  = 1'b0;
   localparam logic RESULT_CHECK = 1'b1;

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
   localparam logic [7:0]  ESC_OFFSET   = 8'd64;
   localparam logic [7:0]  BASE_OFFSET  = 8'd42;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_EQ  = 8'h3D;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  data_byte;
      logic [31:0] expected_crc;
      logic        crc_given;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  decoded_byte;
      logic        status;
      logic [31:0] final_crc;
   } rsp_type;

   typedef struct packed {
      logic advance;
      logic crc_enable;
   } yenc_ctl_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return {8'd0, crc[31:8]} ^ c;
   endfunction

endpackage

// ===== rtl/yenc_body_decoder_crc32.sv =====
// yenc body decoder with crc-32: input register, decode stage, result register
// rsp_valid comes from the result register; one item per cycle, save for stalls:
// the decode stage stalls only while the result register holds an untaken item
// reset (synchronous, active high) clears both stage valids, the escape flag,
// sets the crc to all ones and crc_check_enable to 0
// depends on yenc_pkg, yenc_csr, yenc_decode and assert_macros.svh
`include "assert_macros.svh"
module yenc_body_decoder_crc32
   import yenc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_type      in_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_type      out_data_ff;
   logic         crc_enable;
   logic         advance;
   logic         has_result;
   rsp_type      result;
   yenc_ctl_type ctl;

   yenc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .crc_enable (crc_enable)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready      = !in_valid_ff || advance;
   assign ctl.advance    = advance;
   assign ctl.crc_enable = crc_enable;

   yenc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (in_data_ff),
      .has_result(has_result),
      .result    (result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = has_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance && has_result) begin
         out_data_ff <= result;
      end
   end

   `ASSERT_CLK(a_byte_fields_zero, clock, reset,
      (rsp_valid && rsp_payload.result_kind == RESULT_BYTE) |->
         (!rsp_payload.status && rsp_payload.final_crc == '0),
      "byte item carries check fields")
   `ASSERT_CLK(a_mismatch_needs_enable, clock, reset,
      (advance && has_result && result.status) |-> crc_enable,
      "mismatch reported with checking disabled")
   `ASSERT_CLK(a_stage_holds, clock, reset,
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)),
      "stalled input stage lost its item")

endmodule

// ===== rtl/yenc_csr.sv =====
// configuration register block: apb-style write/read of crc_check_enable
// depends on yenc_pkg
module yenc_csr
   import yenc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic                  crc_enable
);

   logic       enable_ff;
   logic       enable_in;
   logic [0:0] reg_index;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign crc_enable = enable_ff;

   always_comb begin
      enable_in = enable_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          reg_index == REG_CRC_CHECK_ENABLE) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_CRC_CHECK_ENABLE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, enable_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

endmodule

// ===== rtl/yenc_decode.sv =====
// decode stage: escape flag, running crc and result formation for one item
// depends on yenc_pkg and assert_macros.svh
`include "assert_macros.svh"
module yenc_decode
   import yenc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  yenc_ctl_type ctl,
   input  req_type      item,
   output logic         has_result,
   output rsp_type      result
);

   logic        escape_ff;
   logic        escape_in;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [7:0]  dec;
   logic [31:0] fin;

   assign fin = crc_ff ^ CRC_ALL_ONES;

   always_comb begin
      escape_in  = escape_ff;
      crc_in     = crc_ff;
      has_result = 1'b0;
      result     = '0;
      dec        = '0;
      case (item.operation)
         OP_BYTE: begin
            if (escape_ff) begin
               escape_in  = 1'b0;
               dec        = item.data_byte - ESC_OFFSET - BASE_OFFSET;
               has_result = 1'b1;
            end else if (item.data_byte == CHAR_LF || item.data_byte == CHAR_CR ||
                         item.data_byte == CHAR_NUL) begin
               has_result = 1'b0;
            end else if (item.data_byte == CHAR_EQ) begin
               escape_in = 1'b1;
            end else begin
               dec        = item.data_byte - BASE_OFFSET;
               has_result = 1'b1;
            end
            if (has_result && ctl.crc_enable) begin
               crc_in = crc_byte(crc_ff, dec);
            end
            result.result_kind  = RESULT_BYTE;
            result.decoded_byte = dec;
         end
         OP_CHECK: begin
            has_result         = 1'b1;
            result.result_kind = RESULT_CHECK;
            result.final_crc   = fin;
            result.status      = ctl.crc_enable && item.crc_given &&
                                 (item.expected_crc != fin);
         end
         OP_CLEAR: begin
            escape_in = 1'b0;
            crc_in    = CRC_ALL_ONES;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
         crc_ff    <= CRC_ALL_ONES;
      end else if (ctl.advance) begin
         escape_ff <= escape_in;
         crc_ff    <= crc_in;
      end
   end

   `ASSERT_CLK(a_clear_restarts, clock, reset,
      (ctl.advance && item.operation == OP_CLEAR) |=> (crc_ff == CRC_ALL_ONES && !escape_ff),
      "clear item did not restart crc and escape flag")
   `ASSERT_CLK(a_crc_hold_disabled, clock, reset,
      (!ctl.crc_enable && !(ctl.advance && item.operation == OP_CLEAR)) |=> $stable(crc_ff),
      "crc changed while checking is disabled")
   `ASSERT_CLK(a_check_keeps_state, clock, reset,
      (ctl.advance && item.operation == OP_CHECK) |=> ($stable(crc_ff) && $stable(escape_ff)),
      "check item disturbed the stream state")

endmodule
